// File: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master register controller: register
// indexes, bit positions, result kinds, bus phases and the inter-module structs.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Default sizes
    localparam int unsigned RX_DEPTH_DEF  = 256;
    localparam int unsigned REG_WORDS_DEF = 16;

    // Register index width from a 6-bit byte offset
    localparam int unsigned IDX_W = 4;

    // Item opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;

    // Register word indexes
    localparam logic [IDX_W-1:0] W_TX   = 4'd0;
    localparam logic [IDX_W-1:0] W_RX   = 4'd1;
    localparam logic [IDX_W-1:0] W_CNT  = 4'd2;
    localparam logic [IDX_W-1:0] W_STA  = 4'd5;
    localparam logic [IDX_W-1:0] W_MASK = 4'd6;
    localparam logic [IDX_W-1:0] W_CTL  = 4'd7;
    localparam logic [IDX_W-1:0] W_VER  = 4'd10;
    localparam logic [IDX_W-1:0] W_RDC  = 4'd11;

    // Status bit positions
    localparam int unsigned STA_XIP  = 28;
    localparam int unsigned STA_XEN  = 27;
    localparam int unsigned STA_NAK  = 21;
    localparam int unsigned STA_MRF  = 20;
    localparam int unsigned STA_MRNE = 19;

    // TX and CTL bit positions
    localparam int unsigned TX_START    = 8;
    localparam int unsigned TX_STOP     = 9;
    localparam int unsigned TX_READ     = 10;
    localparam int unsigned CTL_RXRESET = 10;

    // Fixed read values
    localparam logic [31:0] RX_EMPTY_WORD = 32'h0000_0100;
    localparam logic [31:0] VERSION_WORD  = 32'd2;

    // Result kinds
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_READ  = 3'd1,
        K_START = 3'd2,
        K_SEND  = 3'd3,
        K_RECV  = 3'd4,
        K_STOP  = 3'd5
    } t_kind;

    // Bus phase: which reply the block waits for
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_START      = 3'd1,
        PH_RESTART_RX = 3'd2,
        PH_RESTART_TX = 3'd3,
        PH_SEND       = 3'd4,
        PH_RECV       = 3'd5
    } t_phase;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [31:0] read_data;
        logic [6:0]  target;
        logic        dir_read;
        logic [7:0]  send_byte;
        logic        irq;
    } t_result;

    // RX FIFO command from the controller
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] data;
    } t_rx_cmd;

endpackage

// File: rtl/i2cm_regmem.sv
// ----------------------------------------------------------------------------
// i2cm_regmem
// Register word memory: one write and one registered read port, with a valid
// bit per word so that unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module i2cm_regmem
    import i2cm_pkg::*;
#(
    parameter int unsigned REG_WORDS = REG_WORDS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(REG_WORDS)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(REG_WORDS)-1:0] i_wr_addr,
    input  logic [31:0]                  i_wr_data,
    output logic [31:0]                  o_rd_data
);

    logic [31:0]          r_mem [REG_WORDS];
    logic [REG_WORDS-1:0] r_valid;
    logic [31:0]          r_rd_data;
    logic                 r_rd_valid;

    // Storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Written flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: rtl/i2cm_rxfifo.sv
// ----------------------------------------------------------------------------
// i2cm_rxfifo
// Receive byte FIFO in a synchronous memory. The head byte is read ahead into
// a register; a push while full drops the byte.
// ----------------------------------------------------------------------------
module i2cm_rxfifo
    import i2cm_pkg::*;
#(
    parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  t_rx_cmd                        i_cmd,
    output logic [7:0]                     o_rd_data,
    output logic [$clog2(RX_DEPTH+1)-1:0]  o_count
);

    localparam int unsigned PW = $clog2(RX_DEPTH);
    localparam int unsigned CW = $clog2(RX_DEPTH + 1);

    logic [7:0]    r_mem [RX_DEPTH];
    logic [7:0]    r_rd_data;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_head;
    logic [PW-1:0] n_tail;
    logic          push_ok;
    logic          pop_ok;

    assign push_ok = i_cmd.push && (r_count != CW'(RX_DEPTH));
    assign pop_ok  = i_cmd.pop && (r_count != '0);

    // Pointer wrap for any depth
    assign n_head = (r_head == PW'(RX_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign n_tail = (r_tail == PW'(RX_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    // Byte storage and head read
    always_ff @(posedge i_clk) begin
        if (push_ok && !i_cmd.clear) begin
            r_mem[r_tail] <= i_cmd.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (push_ok) begin
            r_tail  <= n_tail;
            r_count <= r_count + 1'b1;
        end else if (pop_ok) begin
            r_head  <= n_head;
            r_count <= r_count - 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule

// File: rtl/i2cm_ctrl.sv
// ----------------------------------------------------------------------------
// i2cm_ctrl
// Item execution: decodes one item against the data read from the memories,
// runs the bus phase machine, keeps status, mask and threshold, and forms the
// write-back, the FIFO command and the result.
// ----------------------------------------------------------------------------
module i2cm_ctrl
    import i2cm_pkg::*;
#(
    parameter int unsigned RX_DEPTH = RX_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_exec,
    input  logic [1:0]                    i_op,
    input  logic [IDX_W-1:0]              i_idx,
    input  logic [31:0]                   i_wd,
    input  logic                          i_nak,
    input  logic [7:0]                    i_rb,
    input  logic [31:0]                   i_reg_rdata,
    input  logic [7:0]                    i_rx_rdata,
    input  logic [$clog2(RX_DEPTH+1)-1:0] i_rx_count,
    output logic                          o_reg_wr_en,
    output logic [31:0]                   o_reg_wr_data,
    output t_rx_cmd                       o_rx_cmd,
    output t_result                       o_result
);

    t_phase      r_phase, n_phase;
    logic        r_in_transfer, n_in_transfer;
    logic        r_receiving, n_receiving;
    logic        r_stop_pending, n_stop_pending;
    logic [7:0]  r_receive_left, n_receive_left;
    logic [7:0]  r_receive_asked, n_receive_asked;
    logic [6:0]  r_target, n_target;
    logic [31:0] r_sta, n_sta;
    logic [31:0] r_mask, n_mask;
    logic [7:0]  r_rdc_thr, n_rdc_thr;
    logic [7:0]  r_tx_byte, n_tx_byte;
    logic [31:0] cnt_ext;
    logic        do_fin;
    logic        do_fin_rx;

    assign cnt_ext = 32'(i_rx_count);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_in_transfer   <= 1'b0;
            r_receiving     <= 1'b0;
            r_stop_pending  <= 1'b0;
            r_receive_left  <= '0;
            r_receive_asked <= '0;
            r_target        <= '0;
            r_sta           <= '0;
            r_mask          <= '0;
            r_rdc_thr       <= '0;
            r_tx_byte       <= '0;
        end else begin
            r_phase         <= n_phase;
            r_in_transfer   <= n_in_transfer;
            r_receiving     <= n_receiving;
            r_stop_pending  <= n_stop_pending;
            r_receive_left  <= n_receive_left;
            r_receive_asked <= n_receive_asked;
            r_target        <= n_target;
            r_sta           <= n_sta;
            r_mask          <= n_mask;
            r_rdc_thr       <= n_rdc_thr;
            r_tx_byte       <= n_tx_byte;
        end
    end

    // Item decode, phase machine and result
    always_comb begin
        n_phase         = r_phase;
        n_in_transfer   = r_in_transfer;
        n_receiving     = r_receiving;
        n_stop_pending  = r_stop_pending;
        n_receive_left  = r_receive_left;
        n_receive_asked = r_receive_asked;
        n_target        = r_target;
        n_sta           = r_sta;
        n_mask          = r_mask;
        n_rdc_thr       = r_rdc_thr;
        n_tx_byte       = r_tx_byte;
        o_result        = '0;
        o_result.kind   = K_NONE;
        o_reg_wr_en     = 1'b0;
        o_reg_wr_data   = i_wd;
        o_rx_cmd        = '0;
        o_rx_cmd.data   = i_rb;
        do_fin          = 1'b0;
        do_fin_rx       = 1'b0;

        if (i_exec) begin
            unique case (i_op)
                OP_WRITE: begin
                    if (i_idx == W_TX) begin
                        // TX word; ignored while a reply is awaited
                        if (r_phase == PH_IDLE) begin
                            o_reg_wr_en    = 1'b1;
                            n_tx_byte      = i_wd[7:0];
                            n_stop_pending = i_wd[TX_STOP];
                            if (i_wd[TX_START]) begin
                                n_receiving      = i_wd[0];
                                n_target         = i_wd[7:1];
                                o_result.kind    = K_START;
                                o_result.target  = i_wd[7:1];
                                o_result.dir_read = i_wd[0];
                                n_phase          = PH_START;
                            end else if (r_in_transfer) begin
                                if (i_wd[TX_READ]) begin
                                    n_receive_left  = i_wd[7:0];
                                    n_receive_asked = i_wd[7:0];
                                    if (!r_receiving) begin
                                        // turn around to receive
                                        n_receiving       = 1'b1;
                                        o_result.kind     = K_START;
                                        o_result.target   = r_target;
                                        o_result.dir_read = 1'b1;
                                        n_phase           = PH_RESTART_RX;
                                    end else if (i_wd[7:0] != '0) begin
                                        o_result.kind = K_RECV;
                                        n_phase       = PH_RECV;
                                    end else begin
                                        do_fin_rx = 1'b1;
                                    end
                                end else if (r_receiving) begin
                                    // turn around to send
                                    n_receiving       = 1'b0;
                                    o_result.kind     = K_START;
                                    o_result.target   = r_target;
                                    o_result.dir_read = 1'b0;
                                    n_phase           = PH_RESTART_TX;
                                end else begin
                                    o_result.kind      = K_SEND;
                                    o_result.send_byte = i_wd[7:0];
                                    n_phase            = PH_SEND;
                                end
                            end else begin
                                n_stop_pending = 1'b0;
                            end
                        end
                    end else if (i_idx == W_STA) begin
                        n_sta = r_sta & ~i_wd;
                    end else if (i_idx == W_CTL) begin
                        o_rx_cmd.clear = i_wd[CTL_RXRESET];
                        o_reg_wr_en    = 1'b1;
                        o_reg_wr_data  = '0;
                    end else begin
                        o_reg_wr_en = 1'b1;
                        if (i_idx == W_MASK) begin
                            n_mask = i_wd;
                        end
                        if (i_idx == W_RDC) begin
                            n_rdc_thr = i_wd[15:8];
                        end
                    end
                end
                OP_READ: begin
                    o_result.kind = K_READ;
                    if (i_idx == W_RX) begin
                        if (i_rx_count == '0) begin
                            o_result.read_data = RX_EMPTY_WORD;
                        end else begin
                            o_result.read_data = {24'd0, i_rx_rdata};
                            o_rx_cmd.pop       = 1'b1;
                        end
                    end else if (i_idx == W_CNT) begin
                        o_result.read_data = {i_reg_rdata[31:16], cnt_ext[7:0], 8'd0};
                    end else if (i_idx == W_VER) begin
                        o_result.read_data = VERSION_WORD;
                    end else if (i_idx == W_STA) begin
                        o_result.read_data = r_sta;
                    end else begin
                        o_result.read_data = i_reg_rdata;
                    end
                end
                OP_REPLY: begin
                    unique case (r_phase)
                        PH_START: begin
                            if (i_nak) begin
                                n_sta[STA_NAK] = 1'b1;
                                n_stop_pending = 1'b0;
                                n_phase        = PH_IDLE;
                            end else begin
                                n_in_transfer  = 1'b1;
                                n_sta[STA_XIP] = 1'b1;
                                do_fin         = 1'b1;
                            end
                        end
                        PH_RESTART_RX: begin
                            if (i_nak) begin
                                n_sta[STA_NAK] = 1'b1;
                                n_stop_pending = 1'b0;
                                n_phase        = PH_IDLE;
                            end else if (r_receive_left != '0) begin
                                o_result.kind = K_RECV;
                                n_phase       = PH_RECV;
                            end else begin
                                do_fin_rx = 1'b1;
                            end
                        end
                        PH_RESTART_TX: begin
                            if (i_nak) begin
                                n_sta[STA_NAK] = 1'b1;
                                n_stop_pending = 1'b0;
                                n_phase        = PH_IDLE;
                            end else begin
                                o_result.kind      = K_SEND;
                                o_result.send_byte = r_tx_byte;
                                n_phase            = PH_SEND;
                            end
                        end
                        PH_SEND: begin
                            if (i_nak) begin
                                n_sta[STA_NAK] = 1'b1;
                            end
                            do_fin = 1'b1;
                        end
                        PH_RECV: begin
                            o_rx_cmd.push = 1'b1;
                            if (r_receive_left != '0) begin
                                n_receive_left = r_receive_left - 1'b1;
                            end
                            if (n_receive_left != '0) begin
                                o_result.kind = K_RECV;
                            end else begin
                                do_fin_rx = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        // End of a receive run: flag data and threshold
        if (do_fin_rx) begin
            if (n_receive_asked != '0) begin
                n_sta[STA_MRNE] = 1'b1;
                if (n_receive_asked >= r_rdc_thr) begin
                    n_sta[STA_MRF] = 1'b1;
                end
            end
            do_fin = 1'b1;
        end

        // End of a word: optional stop
        if (do_fin) begin
            if (n_stop_pending && n_in_transfer) begin
                o_result.kind  = K_STOP;
                n_sta[STA_XEN] = 1'b1;
                n_in_transfer  = 1'b0;
            end
            n_stop_pending = 1'b0;
            n_phase        = PH_IDLE;
        end

        o_result.irq = |(n_sta & n_mask);
    end

endmodule

// File: rtl/i2c_master_register_controller.sv
// ----------------------------------------------------------------------------
// i2c_master_register_controller
// I2C master behind 32-bit registers, driven by register and bus reply items.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result item. In the accept cycle the
// register word and the RX FIFO head byte are read from their synchronous
// memories, and in the next cycle the item is executed, the memories are
// written back and the result is registered. With these registered memory
// reads the block cannot take a new item until the current one has executed;
// the input stalls while an item executes or while an unclaimed result is
// held. No clearing pass is needed after reset: register words carry written
// flags and read as zero until written.
module i2c_master_register_controller
    import i2cm_pkg::*;
#(
    parameter int unsigned RX_DEPTH  = RX_DEPTH_DEF,
    parameter int unsigned REG_WORDS = REG_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_reg_offset,
    input  logic [31:0] i_write_data,
    input  logic        i_reply_nak,
    input  logic [7:0]  i_reply_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_result_kind,
    output logic [31:0] o_read_data,
    output logic [6:0]  o_target_address,
    output logic        o_direction_read,
    output logic [7:0]  o_send_byte,
    output logic        o_irq_level
);

    localparam int unsigned AW = $clog2(REG_WORDS);
    localparam int unsigned CW = $clog2(RX_DEPTH + 1);

    logic             accept;
    logic             r_busy;
    logic [1:0]       r_op;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      r_wd;
    logic             r_nak;
    logic [7:0]       r_rb;
    logic             r_out_valid;
    t_result          r_out;
    t_result          result;
    t_rx_cmd          rx_cmd;
    logic             reg_wr_en;
    logic [31:0]      reg_wr_data;
    logic [31:0]      reg_rdata;
    logic [7:0]       rx_rdata;
    logic [CW-1:0]    rx_count;

    // Input handshake: one item in flight
    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    // Busy flag for the execute cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_idx <= i_reg_offset[5:2];
            r_wd  <= i_write_data;
            r_nak <= i_reply_nak;
            r_rb  <= i_reply_byte;
        end
    end

    i2cm_regmem #(
        .REG_WORDS (REG_WORDS)
    ) u_regmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(i_reg_offset[5:2])),
        .i_wr_en   (reg_wr_en),
        .i_wr_addr (AW'(r_idx)),
        .i_wr_data (reg_wr_data),
        .o_rd_data (reg_rdata)
    );

    i2cm_rxfifo #(
        .RX_DEPTH (RX_DEPTH)
    ) u_rxfifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_cmd     (rx_cmd),
        .o_rd_data (rx_rdata),
        .o_count   (rx_count)
    );

    i2cm_ctrl #(
        .RX_DEPTH (RX_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_exec        (r_busy),
        .i_op          (r_op),
        .i_idx         (r_idx),
        .i_wd          (r_wd),
        .i_nak         (r_nak),
        .i_rb          (r_rb),
        .i_reg_rdata   (reg_rdata),
        .i_rx_rdata    (rx_rdata),
        .i_rx_count    (rx_count),
        .o_reg_wr_en   (reg_wr_en),
        .o_reg_wr_data (reg_wr_data),
        .o_rx_cmd      (rx_cmd),
        .o_result      (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_busy) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out.kind;
    assign o_read_data      = r_out.read_data;
    assign o_target_address = r_out.target;
    assign o_direction_read = r_out.dir_read;
    assign o_send_byte      = r_out.send_byte;
    assign o_irq_level      = r_out.irq;

endmodule

// File: rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master register controller, bound to the top.
// ----------------------------------------------------------------------------
module i2cm_checker
    import i2cm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_result_kind,
    input logic [31:0] o_read_data,
    input logic [6:0]  o_target_address,
    input logic        o_direction_read,
    input logic [7:0]  o_send_byte
);

    // A held result keeps its kind and data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_result_kind) && $stable(o_read_data)))
        else $error("held result changed");

    // One item at a time: input stalls right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while another executes");

    // Every accepted item yields a result once it has executed
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> ##2 o_out_valid)
        else $error("result missing after accepted item");

    // Fields outside their result kind are zero
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_result_kind == K_READ || o_read_data == '0)
             && (o_result_kind == K_START
                 || (o_target_address == '0 && !o_direction_read))
             && (o_result_kind == K_SEND || o_send_byte == '0)))
        else $error("field set outside its result kind");

endmodule

bind i2c_master_register_controller i2cm_checker u_i2cm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_result_kind    (o_result_kind),
    .o_read_data      (o_read_data),
    .o_target_address (o_target_address),
    .o_direction_read (o_direction_read),
    .o_send_byte      (o_send_byte)
);

// File: tb/i2c_master_register_controller_checker.sv
// ----------------------------------------------------------------------------
// i2c_master_register_controller_checker
// Watches both channels of the I2C master register controller, keeps its own
// copy of the register file, RX FIFO and bus phase, works out the result of
// every accepted item and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module i2c_master_register_controller_checker
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [5:0]  i_reg_offset,
    input  logic [31:0] i_write_data,
    input  logic        i_reply_nak,
    input  logic [7:0]  i_reply_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_result_kind,
    input  logic [31:0] i_read_data,
    input  logic [6:0]  i_target_address,
    input  logic        i_direction_read,
    input  logic [7:0]  i_send_byte,
    input  logic        i_irq_level,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the controller state
    logic [31:0] regs [REG_WORDS_DEF];
    logic [7:0]  rx_mem [RX_DEPTH_DEF];
    logic [7:0]  rx_rd_ptr;
    logic [7:0]  rx_wr_ptr;
    logic [8:0]  rx_level;
    logic        xfer_open;
    logic        rx_direction;
    logic        stop_req;
    t_phase      phase;
    logic [7:0]  recv_left;
    logic [7:0]  recv_total;
    logic [6:0]  target_cur;

    t_result     outcome;              // result of the item being predicted
    t_result     expected_results [$];
    int          mismatches;

    assign o_fail_count = mismatches;

    function automatic void issue(t_kind k, logic [6:0] tgt, logic dir, logic [7:0] sb);
        outcome.kind      = k;
        outcome.target    = tgt;
        outcome.dir_read  = dir;
        outcome.send_byte = sb;
    endfunction

    // End of a TX word's work: the stop goes out only inside a transfer
    function automatic void end_command();
        if (stop_req && xfer_open) begin
            issue(K_STOP, '0, 1'b0, '0);
            regs[W_STA][STA_XEN] = 1'b1;
            xfer_open = 1'b0;
        end
        stop_req = 1'b0;
        phase    = PH_IDLE;
    endfunction

    function automatic void end_receives();
        if (recv_total != 0) begin
            regs[W_STA][STA_MRNE] = 1'b1;
            if (recv_total >= regs[W_RDC][15:8])
                regs[W_STA][STA_MRF] = 1'b1;
        end
        end_command();
    endfunction

    function automatic void next_receive();
        if (recv_left != 0) begin
            issue(K_RECV, '0, 1'b0, '0);
            phase = PH_RECV;
        end else begin
            end_receives();
        end
    endfunction

    // Start, restart refused: rest of the word is dropped
    function automatic void refuse();
        regs[W_STA][STA_NAK] = 1'b1;
        stop_req = 1'b0;
        phase    = PH_IDLE;
    endfunction

    function automatic void take_tx_word(logic [31:0] v);
        logic [7:0] b;
        b = v[7:0];
        regs[W_TX] = v;
        stop_req   = v[TX_STOP];
        if (v[TX_START]) begin
            rx_direction = b[0];
            target_cur   = b[7:1];
            issue(K_START, target_cur, rx_direction, '0);
            phase = PH_START;
        end else if (xfer_open) begin
            if (v[TX_READ]) begin
                recv_left  = b;
                recv_total = b;
                if (!rx_direction) begin
                    // turn round to receive: re-address first
                    rx_direction = 1'b1;
                    issue(K_START, target_cur, 1'b1, '0);
                    phase = PH_RESTART_RX;
                end else begin
                    next_receive();
                end
            end else if (rx_direction) begin
                rx_direction = 1'b0;
                issue(K_START, target_cur, 1'b0, '0);
                phase = PH_RESTART_TX;
            end else begin
                issue(K_SEND, '0, 1'b0, b);
                phase = PH_SEND;
            end
        end else begin
            stop_req = 1'b0;
        end
    endfunction

    function automatic void take_reply(logic nak, logic [7:0] b);
        case (phase)
            PH_START: begin
                if (nak) begin
                    refuse();
                end else begin
                    xfer_open = 1'b1;
                    regs[W_STA][STA_XIP] = 1'b1;
                    end_command();
                end
            end
            PH_RESTART_RX: begin
                if (nak)
                    refuse();
                else
                    next_receive();
            end
            PH_RESTART_TX: begin
                if (nak) begin
                    refuse();
                end else begin
                    issue(K_SEND, '0, 1'b0, regs[W_TX][7:0]);
                    phase = PH_SEND;
                end
            end
            PH_SEND: begin
                // a refused send still lets the stop through
                if (nak)
                    regs[W_STA][STA_NAK] = 1'b1;
                end_command();
            end
            PH_RECV: begin
                // full FIFO drops the byte
                if (rx_level < RX_DEPTH_DEF) begin
                    rx_mem[rx_wr_ptr] = b;
                    rx_wr_ptr = rx_wr_ptr + 8'd1;
                    rx_level  = rx_level + 9'd1;
                end
                if (recv_left != 0)
                    recv_left = recv_left - 8'd1;
                if (recv_left != 0)
                    issue(K_RECV, '0, 1'b0, '0);
                else
                    end_receives();
            end
            default: phase = PH_IDLE;
        endcase
    endfunction

    function automatic t_result predict_item(logic [1:0] op, logic [5:0] off, logic [31:0] wd,
                                             logic nak, logic [7:0] b);
        logic [IDX_W-1:0] idx;
        logic [31:0]      word;
        outcome      = '0;
        outcome.kind = K_NONE;
        idx          = off[5:2];
        case (op)
            OP_WRITE: begin
                if (idx == W_TX) begin
                    if (phase == PH_IDLE)
                        take_tx_word(wd);
                end else if (idx == W_STA) begin
                    regs[W_STA] = regs[W_STA] & ~wd;
                end else if (idx == W_CTL) begin
                    if (wd[CTL_RXRESET]) begin
                        rx_rd_ptr = '0;
                        rx_wr_ptr = '0;
                        rx_level  = '0;
                    end
                    regs[W_CTL] = '0;
                end else begin
                    regs[idx] = wd;
                end
            end
            OP_READ: begin
                word = regs[idx];
                if (idx == W_RX) begin
                    if (rx_level == 0) begin
                        word = RX_EMPTY_WORD;
                    end else begin
                        word = {24'd0, rx_mem[rx_rd_ptr]};
                        rx_rd_ptr = rx_rd_ptr + 8'd1;
                        rx_level  = rx_level - 9'd1;
                    end
                end else if (idx == W_CNT) begin
                    word = {word[31:16], rx_level[7:0], 8'd0};
                end else if (idx == W_VER) begin
                    word = VERSION_WORD;
                end
                outcome.kind      = K_READ;
                outcome.read_data = word;
            end
            OP_REPLY: take_reply(nak, b);
            default: ;
        endcase
        outcome.irq = |(regs[W_STA] & regs[W_MASK]);
        return outcome;
    endfunction

    function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    // Check results, then predict the item accepted at this edge
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            foreach (regs[k])
                regs[k] = '0;
            rx_rd_ptr    = '0;
            rx_wr_ptr    = '0;
            rx_level     = '0;
            xfer_open    = 1'b0;
            rx_direction = 1'b0;
            stop_req     = 1'b0;
            phase        = PH_IDLE;
            recv_left    = '0;
            recv_total   = '0;
            target_cur   = '0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result item with none expected, actual kind %h",
                             $time, i_result_kind);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("result_kind", 32'(want.kind), 32'(i_result_kind));
                    compare_field("read_data", want.read_data, i_read_data);
                    compare_field("target_address", 32'(want.target), 32'(i_target_address));
                    compare_field("direction_read", 32'(want.dir_read),
                                  32'(i_direction_read));
                    compare_field("send_byte", 32'(want.send_byte), 32'(i_send_byte));
                    compare_field("irq_level", 32'(want.irq), 32'(i_irq_level));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_item(i_opcode, i_reg_offset, i_write_data,
                                                        i_reply_nak, i_reply_byte));
            o_pending <= expected_results.size();
        end
    end

endmodule

// File: tb/i2c_master_register_controller_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_register_controller_tb
// Drives register writes, register reads and bus replies into the I2C master
// register controller: a directed opening, then random transfers, register
// traffic, a FIFO overflow run and noise, with random sender gaps and
// receiver stalls. The checker beside the block does all result checking.
// ----------------------------------------------------------------------------
module i2c_master_register_controller_tb
    import i2cm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         RANDOM_LEN = 600;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode     = OP_WRITE;
    logic [5:0]  reg_offset = '0;
    logic [31:0] write_data = '0;
    logic        reply_nak  = 1'b0;
    logic [7:0]  reply_byte = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [2:0]  result_kind;
    logic [31:0] read_data;
    logic [6:0]  target_address;
    logic        direction_read;
    logic [7:0]  send_byte;
    logic        irq_level;
    int          fail_count;
    int          pending;

    // Sender bookkeeping
    int   burst_left;
    int   items_sent;
    int   n_writes;
    int   n_reads;
    int   n_replies;
    int   n_unused;
    int   n_transfers;
    int   n_fills;
    logic xfer_on;      // rough view of whether a transfer is open
    logic rx_dir;       // rough view of the current direction

    // Receiver stall pattern
    int stall_pct;
    int stall_span;

    i2c_master_register_controller dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_reg_offset     (reg_offset),
        .i_write_data     (write_data),
        .i_reply_nak      (reply_nak),
        .i_reply_byte     (reply_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_result_kind    (result_kind),
        .o_read_data      (read_data),
        .o_target_address (target_address),
        .o_direction_read (direction_read),
        .o_send_byte      (send_byte),
        .o_irq_level      (irq_level)
    );

    i2c_master_register_controller_checker bus_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_reg_offset     (reg_offset),
        .i_write_data     (write_data),
        .i_reply_nak      (reply_nak),
        .i_reply_byte     (reply_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_result_kind    (result_kind),
        .i_read_data      (read_data),
        .i_target_address (target_address),
        .i_direction_read (direction_read),
        .i_send_byte      (send_byte),
        .i_irq_level      (irq_level),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #4 clk = ~clk;

    // Receiver: stall rate is redrawn after each random span, zero included
    always @(posedge clk) begin
        if (stall_span == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            stall_span = $urandom_range(20, 200);
        end
        stall_span--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // One item: bursts of random length, random gap between bursts
    task automatic push_item(logic [1:0] op, logic [5:0] off, logic [31:0] wd,
                             logic nak, logic [7:0] rb);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid   <= 1'b1;
        opcode     <= op;
        reg_offset <= off;
        write_data <= wd;
        reply_nak  <= nak;
        reply_byte <= rb;
        do @(posedge clk); while (in_stall);
        items_sent++;
        case (op)
            OP_WRITE: n_writes++;
            OP_READ:  n_reads++;
            OP_REPLY: n_replies++;
            default:  n_unused++;
        endcase
    endtask

    // Hold off until every expected result has come back
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Low offset bits are ignored by the block, so they are random
    task automatic reg_write(logic [IDX_W-1:0] idx, logic [31:0] wd);
        logic [1:0] low;
        logic       nak;
        logic [7:0] rb;
        low = 2'($urandom);
        nak = 1'($urandom);
        rb  = 8'($urandom);
        push_item(OP_WRITE, {idx, low}, wd, nak, rb);
    endtask

    task automatic reg_read(logic [IDX_W-1:0] idx);
        logic [1:0] low;
        logic       nak;
        logic [7:0] rb;
        low = 2'($urandom);
        nak = 1'($urandom);
        rb  = 8'($urandom);
        push_item(OP_READ, {idx, low}, $urandom, nak, rb);
    endtask

    task automatic bus_reply(logic nak, logic [7:0] b);
        logic [5:0] off;
        off = 6'($urandom);
        push_item(OP_REPLY, off, $urandom, nak, b);
    endtask

    task automatic noise_item();
        logic [1:0] op;
        logic [5:0] off;
        logic       nak;
        logic [7:0] rb;
        op  = 2'($urandom);
        off = 6'($urandom);
        nak = 1'($urandom);
        rb  = 8'($urandom);
        push_item(op, off, $urandom, nak, rb);
    endtask

    // TX word; upper bits random since they are only stored
    function automatic logic [31:0] tx_bits(logic start, logic stop, logic rd, logic [7:0] b);
        logic [31:0] w;
        w           = $urandom;
        w[TX_START] = start;
        w[TX_STOP]  = stop;
        w[TX_READ]  = rd;
        w[7:0]      = b;
        return w;
    endfunction

    // Register traffic outside the TX path
    task automatic poke_registers();
        logic [31:0] w;
        logic [7:0]  thresh;
        w      = $urandom;
        thresh = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        case ($urandom_range(0, 9))
            0: reg_read(W_STA);
            1: reg_write(W_STA, ($urandom_range(0, 1) == 0) ? 32'hffff_ffff : w);
            2: begin
                case ($urandom_range(0, 2))
                    0: reg_write(W_MASK, w);
                    1: reg_write(W_MASK, 32'hffff_ffff);
                    default: reg_write(W_MASK, '0);
                endcase
            end
            3: reg_read(W_CNT);
            4: reg_read(W_RX);
            5: reg_write(W_RDC, {w[31:16], thresh, w[7:0]});
            6: reg_write(W_CTL, w);
            7: reg_read(IDX_W'($urandom_range(0, 15)));
            8: reg_write(IDX_W'($urandom_range(1, 15)), w);
            default: reg_read(W_RDC);
        endcase
    endtask

    // Start, then a few sends and receives, last one maybe with a stop
    task automatic run_transfer(int n_ops);
        logic [7:0] addr_byte;
        logic       nak;
        logic       stop_now;
        logic       last;
        int         count;
        addr_byte = 8'($urandom);
        stop_now  = ($urandom_range(0, 15) == 0);
        reg_write(W_TX, tx_bits(1'b1, stop_now, 1'($urandom_range(0, 1)), addr_byte));
        n_transfers++;
        rx_dir = addr_byte[0];
        nak    = ($urandom_range(0, 9) == 0);
        bus_reply(nak, 8'($urandom));
        if (nak)
            return;
        xfer_on = !stop_now;
        for (int k = 0; k < n_ops && xfer_on; k++) begin
            last = (k == n_ops - 1) && ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 4) == 0)
                poke_registers();
            if ($urandom_range(0, 1) == 0) begin
                count = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
                reg_write(W_TX, tx_bits(1'b0, last, 1'b1, 8'(count)));
                if (!rx_dir) begin
                    rx_dir = 1'b1;
                    nak    = ($urandom_range(0, 11) == 0);
                    bus_reply(nak, 8'($urandom));
                    if (nak)
                        return;
                end
                repeat (count) bus_reply(1'($urandom_range(0, 1)), 8'($urandom));
            end else begin
                reg_write(W_TX, tx_bits(1'b0, last, 1'b0, 8'($urandom)));
                if (rx_dir) begin
                    rx_dir = 1'b0;
                    nak    = ($urandom_range(0, 11) == 0);
                    bus_reply(nak, 8'($urandom));
                    if (nak)
                        return;
                end
                bus_reply($urandom_range(0, 7) == 0, 8'($urandom));
            end
            if (last)
                xfer_on = 1'b0;
        end
    endtask

    // Push the RX FIFO past its capacity, then drain a little and reset it
    task automatic fill_rx_fifo();
        logic [7:0] addr_byte;
        addr_byte    = 8'($urandom);
        addr_byte[0] = 1'b1;
        reg_write(W_TX, tx_bits(1'b1, 1'b0, 1'b0, addr_byte));
        bus_reply(1'b0, 8'($urandom));
        rx_dir  = 1'b1;
        xfer_on = 1'b1;
        reg_write(W_TX, tx_bits(1'b0, 1'b0, 1'b1, 8'hff));
        repeat (255) bus_reply(1'($urandom_range(0, 1)), 8'($urandom));
        reg_read(W_CNT);
        reg_write(W_TX, tx_bits(1'b0, 1'b1, 1'b1, 8'd8));
        repeat (8) bus_reply(1'($urandom_range(0, 1)), 8'($urandom));
        xfer_on = 1'b0;
        reg_read(W_CNT);
        reg_read(W_STA);
        repeat (4) reg_read(W_RX);
        reg_write(W_CTL, tx_bits(1'b0, 1'b0, 1'b1, 8'($urandom)));
        reg_read(W_RX);
        reg_read(W_CNT);
        n_fills++;
    endtask

    // Stimulus
    initial begin
        int stop_at;
        int fill_at;
        int next_drain;
        int pick;
        xfer_on = 1'b0;
        rx_dir  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fixed reads, irq on every status bit, threshold of two
        reg_read(W_VER);
        reg_read(W_RX);
        reg_write(W_MASK, 32'hffff_ffff);
        reg_write(W_RDC, 32'h0000_0200);
        // TX word with no transfer open is only stored; stray reply ignored
        reg_write(W_TX, 32'h0000_02ff);
        bus_reply(1'b1, 8'hff);
        push_item(OP_UNUSED, 6'h3f, 32'hffff_ffff, 1'b1, 8'hff);
        // write to address 0, send refused, stop still goes out
        reg_write(W_TX, tx_bits(1'b1, 1'b0, 1'b0, 8'h00));
        bus_reply(1'b0, 8'h00);
        reg_write(W_TX, tx_bits(1'b0, 1'b1, 1'b0, 8'hff));
        bus_reply(1'b1, 8'h00);
        // read two bytes from 0x7f, then turn round to send with stop
        reg_write(W_TX, tx_bits(1'b1, 1'b0, 1'b0, 8'hff));
        bus_reply(1'b0, 8'h00);
        reg_write(W_TX, tx_bits(1'b0, 1'b0, 1'b1, 8'd2));
        bus_reply(1'b0, 8'h00);
        bus_reply(1'b0, 8'hff);
        reg_write(W_TX, tx_bits(1'b0, 1'b1, 1'b0, 8'ha5));
        bus_reply(1'b0, 8'h00);
        bus_reply(1'b0, 8'h00);
        // refused start drops its stop
        reg_write(W_TX, tx_bits(1'b1, 1'b1, 1'b0, 8'h42));
        bus_reply(1'b1, 8'h00);
        // TX word while a reply is awaited is ignored
        reg_write(W_TX, tx_bits(1'b1, 1'b0, 1'b0, 8'h10));
        reg_write(W_TX, tx_bits(1'b0, 1'b1, 1'b0, 8'h77));
        bus_reply(1'b0, 8'h00);
        // zero-length receive: restart only, then the stop
        reg_write(W_TX, tx_bits(1'b0, 1'b1, 1'b1, 8'd0));
        bus_reply(1'b0, 8'h00);
        drain();

        // random part
        stop_at    = items_sent + RANDOM_LEN;
        fill_at    = items_sent + $urandom_range(100, 250);
        next_drain = items_sent + 150;
        while (items_sent < stop_at) begin
            if (n_fills == 0 && items_sent >= fill_at) begin
                drain();
                bus_reply(1'b0, 8'($urandom));
                fill_rx_fifo();
            end else if (items_sent >= next_drain) begin
                drain();
                next_drain = items_sent + 150;
            end
            pick = $urandom_range(0, 19);
            if (pick < 12)
                run_transfer($urandom_range(1, 5));
            else if (pick < 17)
                poke_registers();
            else
                noise_item();
        end

        drain();
        repeat (16) @(posedge clk);
        $display("covered %0d items: %0d register writes, %0d reads, %0d bus replies, %0d unused",
                 items_sent, n_writes, n_reads, n_replies, n_unused);
        $display("%0d transfers started, %0d RX FIFO overflow runs", n_transfers, n_fills);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("timeout with %0d results still expected", pending);
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/i2cm_pkg.sv
rtl/i2cm_regmem.sv
rtl/i2cm_rxfifo.sv
rtl/i2cm_ctrl.sv
rtl/i2c_master_register_controller.sv
rtl/i2cm_checker.sv
tb/i2c_master_register_controller_checker.sv
tb/i2c_master_register_controller_tb.sv
